// ===== rtl/quaternion_vector_rotation_core_defines.svh =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation core: assertion macros
// Shared concurrent assertion forms for the rotation core.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATION_CORE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QVR_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("qvr: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QVR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("qvr: assertion failed");

`endif

// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Configuration port types, register indexes and pipeline depth.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_REGS   = 7;
  localparam int PIPE_STAGES = 5;

  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [REG_IDX_W-1:0]  reg_idx_t;

  localparam reg_idx_t REG_QUAT_W  = 3'd0;
  localparam reg_idx_t REG_QUAT_X  = 3'd1;
  localparam reg_idx_t REG_QUAT_Y  = 3'd2;
  localparam reg_idx_t REG_QUAT_Z  = 3'd3;
  localparam reg_idx_t REG_PIVOT_X = 3'd4;
  localparam reg_idx_t REG_PIVOT_Y = 3'd5;
  localparam reg_idx_t REG_PIVOT_Z = 3'd6;

endpackage

// ===== rtl/qvr_vec_if.sv =====
// ----------------------------------------------------------------------------
// Point input channel
// Valid/ready channel that carries one point per transaction.
// ----------------------------------------------------------------------------
interface qvr_vec_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vec_x;
  logic signed [COORD_WIDTH-1:0] vec_y;
  logic signed [COORD_WIDTH-1:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// ===== rtl/qvr_rot_if.sv =====
// ----------------------------------------------------------------------------
// Rotated point output channel
// Valid/ready channel that carries one rotated point and its clip flag.
// ----------------------------------------------------------------------------
interface qvr_rot_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rot_x;
  logic signed [COORD_WIDTH-1:0] rot_y;
  logic signed [COORD_WIDTH-1:0] rot_z;
  logic                          clipped;

  modport source (output valid, output rot_x, output rot_y, output rot_z,
                  output clipped, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                  input clipped, output ready);
endinterface

// ===== rtl/qvr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation configuration registers
// APB-style register file holding the quaternion and the pivot point.
// ----------------------------------------------------------------------------
module qvr_cfg_regs #(
  parameter int COORD_WIDTH = 24,
  parameter int QUAT_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  qvr_pkg::cfg_addr_t            paddr,
  input  qvr_pkg::cfg_data_t            pwdata,
  output qvr_pkg::cfg_data_t            prdata,
  output logic                          pready,
  output logic signed [QUAT_WIDTH-1:0]  quat_w,
  output logic signed [QUAT_WIDTH-1:0]  quat_x,
  output logic signed [QUAT_WIDTH-1:0]  quat_y,
  output logic signed [QUAT_WIDTH-1:0]  quat_z,
  output logic signed [COORD_WIDTH-1:0] pivot_x,
  output logic signed [COORD_WIDTH-1:0] pivot_y,
  output logic signed [COORD_WIDTH-1:0] pivot_z
);

  localparam logic [QUAT_WIDTH-1:0] QW_RESET = QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);

  logic [QUAT_WIDTH-1:0]  qw_r, qx_r, qy_r, qz_r;
  logic [COORD_WIDTH-1:0] px_r, py_r, pz_r;
  logic                   wr_en;
  qvr_pkg::reg_idx_t      idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[qvr_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r <= QW_RESET;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
      px_r <= '0;
      py_r <= '0;
      pz_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        qvr_pkg::REG_QUAT_W:  qw_r <= pwdata[QUAT_WIDTH-1:0];
        qvr_pkg::REG_QUAT_X:  qx_r <= pwdata[QUAT_WIDTH-1:0];
        qvr_pkg::REG_QUAT_Y:  qy_r <= pwdata[QUAT_WIDTH-1:0];
        qvr_pkg::REG_QUAT_Z:  qz_r <= pwdata[QUAT_WIDTH-1:0];
        qvr_pkg::REG_PIVOT_X: px_r <= pwdata[COORD_WIDTH-1:0];
        qvr_pkg::REG_PIVOT_Y: py_r <= pwdata[COORD_WIDTH-1:0];
        qvr_pkg::REG_PIVOT_Z: pz_r <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qvr_pkg::REG_QUAT_W:  prdata = qvr_pkg::cfg_data_t'(qw_r);
      qvr_pkg::REG_QUAT_X:  prdata = qvr_pkg::cfg_data_t'(qx_r);
      qvr_pkg::REG_QUAT_Y:  prdata = qvr_pkg::cfg_data_t'(qy_r);
      qvr_pkg::REG_QUAT_Z:  prdata = qvr_pkg::cfg_data_t'(qz_r);
      qvr_pkg::REG_PIVOT_X: prdata = qvr_pkg::cfg_data_t'(px_r);
      qvr_pkg::REG_PIVOT_Y: prdata = qvr_pkg::cfg_data_t'(py_r);
      qvr_pkg::REG_PIVOT_Z: prdata = qvr_pkg::cfg_data_t'(pz_r);
      default:              prdata = '0;
    endcase
  end

  assign quat_w  = qw_r;
  assign quat_x  = qx_r;
  assign quat_y  = qy_r;
  assign quat_z  = qz_r;
  assign pivot_x = px_r;
  assign pivot_y = py_r;
  assign pivot_z = pz_r;

endmodule

// ===== rtl/quaternion_vector_rotation_core.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation core
// Path: each point is registered in the difference, coefficient, product, sum and saturate stages in order.
// Throughput: one point per cycle while the output accepts, set by the five-stage multiply pipeline.
// Reset: synchronous; pipeline emptied, quaternion set to identity, pivot 0.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotation_core_defines.svh"

module quaternion_vector_rotation_core #(
  parameter int COORD_WIDTH = 24,
  parameter int QUAT_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  qvr_vec_if.sink            in_chan,
  qvr_rot_if.source          out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  qvr_pkg::cfg_addr_t paddr,
  input  qvr_pkg::cfg_data_t pwdata,
  output qvr_pkg::cfg_data_t prdata,
  output logic               pready
);

  localparam int NSTG = qvr_pkg::PIPE_STAGES;
  localparam int PW2  = 2 * QUAT_WIDTH;
  localparam int MW   = PW2 + 2;
  localparam int DW   = COORD_WIDTH + 1;
  localparam int PRW  = MW + DW;
  localparam int AW   = PRW + 2;
  localparam int FRAC = 2 * (QUAT_WIDTH - 2);
  localparam int SW   = AW - FRAC;
  localparam int TW   = SW + 1;

  localparam logic signed [AW-1:0] RND = AW'(1) << (FRAC - 1);
  localparam logic signed [TW-1:0] SAT_HI =
    {{(TW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;

  logic signed [QUAT_WIDTH-1:0]  qw, qx, qy, qz;
  logic signed [COORD_WIDTH-1:0] piv [3];

  logic [NSTG-1:0] vld_r, vld_nxt, load;

  logic signed [DW-1:0]  d1_r [3], d1_nxt [3];
  logic signed [DW-1:0]  d2_r [3];
  logic signed [PW2-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [MW-1:0]  coef_r [9], coef_nxt [9];
  logic signed [PRW-1:0] prod_r [9], prod_nxt [9];
  logic signed [AW-1:0]  acc_r [3], acc_nxt [3];
  logic signed [AW-1:0]  shd [3];
  logic signed [TW-1:0]  tot [3];
  logic signed [COORD_WIDTH-1:0] rot_r [3], rot_nxt [3];
  logic [2:0]            ovf;
  logic                  clip_r, clip_nxt;

  qvr_cfg_regs #(
    .COORD_WIDTH (COORD_WIDTH),
    .QUAT_WIDTH  (QUAT_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quat_w  (qw),
    .quat_x  (qx),
    .quat_y  (qy),
    .quat_z  (qz),
    .pivot_x (piv[0]),
    .pivot_y (piv[1]),
    .pivot_z (piv[2])
  );

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    load[NSTG-1] = !vld_r[NSTG-1] || out_chan.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !vld_r[k] || load[k+1];
    end
    vld_nxt[0] = load[0] ? in_chan.valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = load[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_chan.ready = load[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign d1_nxt[0] = DW'(in_chan.vec_x) - DW'(piv[0]);
  assign d1_nxt[1] = DW'(in_chan.vec_y) - DW'(piv[1]);
  assign d1_nxt[2] = DW'(in_chan.vec_z) - DW'(piv[2]);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      d1_r <= d1_nxt;
      ww_r <= PW2'(qw) * PW2'(qw);
      xx_r <= PW2'(qx) * PW2'(qx);
      yy_r <= PW2'(qy) * PW2'(qy);
      zz_r <= PW2'(qz) * PW2'(qz);
      xy_r <= PW2'(qx) * PW2'(qy);
      xz_r <= PW2'(qx) * PW2'(qz);
      yz_r <= PW2'(qy) * PW2'(qz);
      wx_r <= PW2'(qw) * PW2'(qx);
      wy_r <= PW2'(qw) * PW2'(qy);
      wz_r <= PW2'(qw) * PW2'(qz);
    end
  end

  always_comb begin
    coef_nxt[0] = MW'(ww_r) + MW'(xx_r) - MW'(yy_r) - MW'(zz_r);
    coef_nxt[1] = (MW'(xy_r) - MW'(wz_r)) <<< 1;
    coef_nxt[2] = (MW'(xz_r) + MW'(wy_r)) <<< 1;
    coef_nxt[3] = (MW'(xy_r) + MW'(wz_r)) <<< 1;
    coef_nxt[4] = MW'(ww_r) - MW'(xx_r) + MW'(yy_r) - MW'(zz_r);
    coef_nxt[5] = (MW'(yz_r) - MW'(wx_r)) <<< 1;
    coef_nxt[6] = (MW'(xz_r) - MW'(wy_r)) <<< 1;
    coef_nxt[7] = (MW'(yz_r) + MW'(wx_r)) <<< 1;
    coef_nxt[8] = MW'(ww_r) - MW'(xx_r) - MW'(yy_r) + MW'(zz_r);
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      coef_r <= coef_nxt;
      d2_r   <= d1_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_nxt[k] = PRW'(coef_r[k]) * PRW'(d2_r[k % 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = AW'(prod_r[3*k]) + AW'(prod_r[3*k+1]) + AW'(prod_r[3*k+2]) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shd[k] = acc_r[k] >>> FRAC;
      tot[k] = TW'($signed(shd[k][SW-1:0])) + TW'(piv[k]);
      if (tot[k] > SAT_HI) begin
        rot_nxt[k] = SAT_HI[COORD_WIDTH-1:0];
        ovf[k]     = 1'b1;
      end else if (tot[k] < SAT_LO) begin
        rot_nxt[k] = SAT_LO[COORD_WIDTH-1:0];
        ovf[k]     = 1'b1;
      end else begin
        rot_nxt[k] = tot[k][COORD_WIDTH-1:0];
        ovf[k]     = 1'b0;
      end
    end
    clip_nxt = |ovf;
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      rot_r  <= rot_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_chan.valid   = vld_r[NSTG-1];
  assign out_chan.rot_x   = rot_r[0];
  assign out_chan.rot_y   = rot_r[1];
  assign out_chan.rot_z   = rot_r[2];
  assign out_chan.clipped = clip_r;

  `QVR_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, !load[0],
                   (&vld_r) && !out_chan.ready)
  `QVR_ASSERT_NEXT(a_last_stage_handoff, clk, rst_n, vld_r[NSTG-2] && load[NSTG-1],
                   vld_r[NSTG-1])
  `QVR_ASSERT_IMPL(a_clip_at_limit, clk, rst_n, vld_r[NSTG-1] && clip_r,
                   (rot_r[0] == SAT_HI[COORD_WIDTH-1:0]) ||
                   (rot_r[0] == SAT_LO[COORD_WIDTH-1:0]) ||
                   (rot_r[1] == SAT_HI[COORD_WIDTH-1:0]) ||
                   (rot_r[1] == SAT_LO[COORD_WIDTH-1:0]) ||
                   (rot_r[2] == SAT_HI[COORD_WIDTH-1:0]) ||
                   (rot_r[2] == SAT_LO[COORD_WIDTH-1:0]))

endmodule
